// ----- rtl/idt_pkg.sv -----
// Shared constants, types and token codes for the indent/dedent tracker.
package idt_pkg;

  // Stack geometry: the base entry (always zero) plus one cell per deeper level.
  localparam int STACK_DEPTH = 32;
  localparam int CELL_COUNT  = STACK_DEPTH - 1;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int WIDTH_W     = 11;

  // Token kinds carried on the result channel.
  localparam logic [2:0] KIND_INDENT       = 3'd0;
  localparam logic [2:0] KIND_DEDENT       = 3'd1;
  localparam logic [2:0] KIND_END          = 3'd2;
  localparam logic [2:0] KIND_INCONSISTENT = 3'd3;
  localparam logic [2:0] KIND_OVERFLOW     = 3'd4;

  // Shift command broadcast along the row of stack cells.
  typedef struct packed {
    logic push;
    logic pop;
  } idt_shift_t;

endpackage

// ----- rtl/idt_cell.sv -----
// One stack cell: holds a single indent width and shifts with its neighbours.
module idt_cell (
  input  logic                           clk_i,
  input  idt_pkg::idt_shift_t            shift_i,
  input  logic [idt_pkg::WIDTH_W-1:0]    above_i,
  input  logic [idt_pkg::WIDTH_W-1:0]    below_i,
  output logic [idt_pkg::WIDTH_W-1:0]    value_o
);

  logic [idt_pkg::WIDTH_W-1:0] value_q;
  logic [idt_pkg::WIDTH_W-1:0] value_d;

  // A push takes the value from the cell nearer the top; a pop takes it from below.
  always_comb begin
    value_d = value_q;
    if (shift_i.push) begin
      value_d = above_i;
    end else if (shift_i.pop) begin
      value_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ----- rtl/indent_dedent_tracker_core.sv -----
// Top level of the indent/dedent tracker: control sequencer and row of stack cells.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_stall_o    | action, space_count, tab_count, is_blank
//   out     | output    | out_valid_o / out_stall_i  | token_kind, last
//
// One item is worked on at a time. It is accepted in S_IDLE, then S_RUN gives its results in turn:
// an indent, overflow or halted item gives one result, a blank or equal-width item none, a dedent
// run one dedent per pop of the cell row (one pop per cycle while the output can take it), plus an
// inconsistency error if it ends between levels, and an end item a dedent per level, then the end.
// Reset (rst_ni low, asynchronous) empties the stack to its base entry and clears the halt.
// A stall on the output holds the result register and pauses the sequencer; in_stall_o stays
// high until the last result of the current item has entered the output register.
module indent_dedent_tracker_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] space_count_i,
  input  logic [7:0] tab_count_i,
  input  logic       is_blank_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] token_kind_o,
  output logic       last_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  localparam logic [idt_pkg::PTR_W-1:0] PTR_MAX = idt_pkg::PTR_W'(idt_pkg::STACK_DEPTH - 1);
  localparam logic [idt_pkg::PTR_W-1:0] PTR_ONE = idt_pkg::PTR_W'(1);

  logic                             state_q, state_d;
  logic [idt_pkg::PTR_W-1:0]        ptr_q, ptr_d;
  logic                             halted_q, halted_d;
  logic [2:0]                       halt_kind_q, halt_kind_d;
  logic                             popped_q, popped_d;
  logic                             out_valid_q, out_valid_d;
  logic [2:0]                       out_kind_q;
  logic                             out_last_q;

  logic                             act_q;
  logic                             blank_q;
  logic [idt_pkg::WIDTH_W-1:0]      width_q;

  logic                             in_accept;
  logic                             out_free;
  logic                             emit;
  logic [2:0]                       emit_kind;
  logic                             emit_last;
  logic                             done;
  logic                             cont;
  idt_pkg::idt_shift_t              shift;
  logic [idt_pkg::WIDTH_W-1:0]      top_val;
  logic [idt_pkg::WIDTH_W-1:0]      next_val;
  logic [idt_pkg::WIDTH_W-1:0]      line_width;
  logic [idt_pkg::WIDTH_W-1:0]      cell_val [idt_pkg::CELL_COUNT+1];

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Each space is worth one column and each tab four.
  assign line_width = {3'b000, space_count_i} + {1'b0, tab_count_i, 2'b00};

  // The top entry lives in cell 0; the base entry reads as zero.
  assign top_val  = (ptr_q == '0) ? '0 : cell_val[0];
  assign next_val = (ptr_q > PTR_ONE) ? cell_val[1] : '0;

  // Row of stack cells; the cell below the deepest one feeds zeros on a pop.
  assign cell_val[idt_pkg::CELL_COUNT] = '0;
  for (genvar g = 0; g < idt_pkg::CELL_COUNT; g++) begin : g_cell
    idt_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .above_i ((g == 0) ? width_q : cell_val[(g == 0) ? 0 : g - 1]),
      .below_i (cell_val[g + 1]),
      .value_o (cell_val[g])
    );
  end

  // Sequencer: one result, or one decision, per cycle while the output register can take it.
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    halted_d    = halted_q;
    halt_kind_d = halt_kind_q;
    popped_d    = popped_q;
    shift       = '0;
    emit        = 1'b0;
    emit_kind   = idt_pkg::KIND_END;
    emit_last   = 1'b0;
    done        = 1'b0;
    cont        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d  = S_RUN;
          popped_d = 1'b0;
        end
      end
      S_RUN: begin
        if (out_free) begin
          if (halted_q) begin
            emit      = 1'b1;
            emit_kind = halt_kind_q;
            emit_last = 1'b1;
            done      = 1'b1;
          end else if (act_q) begin
            // End of input unwinds every level, then reports the end.
            emit = 1'b1;
            if (ptr_q != '0) begin
              shift.pop = 1'b1;
              ptr_d     = ptr_q - PTR_ONE;
              emit_kind = idt_pkg::KIND_DEDENT;
            end else begin
              emit_kind = idt_pkg::KIND_END;
              emit_last = 1'b1;
              done      = 1'b1;
            end
          end else if (blank_q || width_q == top_val) begin
            done = 1'b1;
          end else if (width_q > top_val) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            done      = 1'b1;
            if (popped_q) begin
              // Dedent landed between two levels.
              emit_kind   = idt_pkg::KIND_INCONSISTENT;
              halted_d    = 1'b1;
              halt_kind_d = idt_pkg::KIND_INCONSISTENT;
            end else if (ptr_q == PTR_MAX) begin
              emit_kind   = idt_pkg::KIND_OVERFLOW;
              halted_d    = 1'b1;
              halt_kind_d = idt_pkg::KIND_OVERFLOW;
            end else begin
              shift.push = 1'b1;
              ptr_d      = ptr_q + PTR_ONE;
              emit_kind  = idt_pkg::KIND_INDENT;
            end
          end else begin
            // Shallower line: pop one level and look ahead at the entry beneath.
            shift.pop = 1'b1;
            ptr_d     = ptr_q - PTR_ONE;
            popped_d  = 1'b1;
            emit      = 1'b1;
            emit_kind = idt_pkg::KIND_DEDENT;
            cont      = (ptr_q > PTR_ONE) && (width_q < next_val);
            emit_last = !cont && (width_q == next_val);
            done      = emit_last;
          end
          if (done) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register hand-off.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      halted_q    <= 1'b0;
      halt_kind_q <= idt_pkg::KIND_INDENT;
      popped_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      halted_q    <= halted_d;
      halt_kind_q <= halt_kind_d;
      popped_q    <= popped_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Captured item and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q   <= action_i;
      blank_q <= is_blank_i;
      width_q <= line_width;
    end
    if (emit) begin
      out_kind_q <= emit_kind;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign token_kind_o = out_kind_q;
  assign last_o       = out_last_q;

endmodule

// ----- rtl/idt_checker.sv -----
// Port-level checks for the indent/dedent tracker, bound to the top level.
module idt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] token_kind_o,
  input logic       last_o
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) && $stable(last_o))
    else $error("stalled result changed");

  // An accepted item closes the input straight after it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input reopened straight after accepting an item");

  // Only defined token kinds appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= idt_pkg::KIND_OVERFLOW)
    else $error("undefined token kind");

  // Every kind other than a dedent closes the results of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != idt_pkg::KIND_DEDENT |-> last_o)
    else $error("non-dedent token without last");

endmodule

bind indent_dedent_tracker_core idt_checker u_idt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .token_kind_o (token_kind_o),
  .last_o       (last_o)
);
